// ----- rtl/core/ookpe_pkg.sv -----
`timescale 1ns / 1ps

package ookpe_pkg;

    // Field and register widths
    localparam int FACT_W     = 8;
    localparam int UNIT_W     = 12;
    localparam int DUR_W      = 15;
    localparam int PROD_W     = FACT_W + UNIT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Longest half symbol in ticks
    localparam logic [PROD_W-1:0] MAX_HALF_TICKS = PROD_W'(32767);

    // Register reset values
    localparam logic [FACT_W-1:0] RST_ONE_HIGH  = 8'd1;
    localparam logic [FACT_W-1:0] RST_ONE_LOW   = 8'd3;
    localparam logic [FACT_W-1:0] RST_ZERO_HIGH = 8'd3;
    localparam logic [FACT_W-1:0] RST_ZERO_LOW  = 8'd1;
    localparam logic [FACT_W-1:0] RST_SYNC_HIGH = 8'd1;
    localparam logic [FACT_W-1:0] RST_SYNC_LOW  = 8'd31;
    localparam logic [UNIT_W-1:0] RST_UNIT      = 12'd350;

    // Command codes
    localparam logic CMD_BIT  = 1'b0;
    localparam logic CMD_SYNC = 1'b1;

    // Line levels
    localparam logic LVL_LOW  = 1'b0;
    localparam logic LVL_HIGH = 1'b1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ONE_HIGH  = 3'd0,
        CFG_ONE_LOW   = 3'd1,
        CFG_ZERO_HIGH = 3'd2,
        CFG_ZERO_LOW  = 3'd3,
        CFG_SYNC_HIGH = 3'd4,
        CFG_SYNC_LOW  = 3'd5,
        CFG_INVERTED  = 3'd6,
        CFG_UNIT      = 3'd7
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_EMIT_HI,
        ST_EMIT_LO
    } t_state;

    // Current configuration
    typedef struct packed {
        logic [FACT_W-1:0] one_high_factor;
        logic [FACT_W-1:0] one_low_factor;
        logic [FACT_W-1:0] zero_high_factor;
        logic [FACT_W-1:0] zero_low_factor;
        logic [FACT_W-1:0] sync_high_factor;
        logic [FACT_W-1:0] sync_low_factor;
        logic              inverted_mode;
        logic [UNIT_W-1:0] pulse_unit;
    } t_cfg;

    // One output symbol
    typedef struct packed {
        logic [DUR_W-1:0] first_duration;
        logic             first_level;
        logic [DUR_W-1:0] second_duration;
        logic             second_level;
        logic             from_sync;
        logic             last_symbol;
    } t_sym;

endpackage

// ----- rtl/core/ookpe_ifs.sv -----
`timescale 1ns / 1ps

// Request channel
interface ookpe_in_if;
    logic valid;
    logic ready;
    logic command;
    logic bit_value;

    modport source (output valid, command, bit_value, input ready);
    modport sink   (input valid, command, bit_value, output ready);
endinterface

// Symbol channel
interface ookpe_out_if;
    import ookpe_pkg::*;
    logic             valid;
    logic             ready;
    logic [DUR_W-1:0] first_duration;
    logic             first_level;
    logic [DUR_W-1:0] second_duration;
    logic             second_level;
    logic             from_sync;
    logic             last_symbol;

    modport source (output valid, first_duration, first_level, second_duration,
                    second_level, from_sync, last_symbol, input ready);
    modport sink   (input valid, first_duration, first_level, second_duration,
                    second_level, from_sync, last_symbol, output ready);
endinterface

// Register write channel
interface ookpe_cfg_if;
    import ookpe_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/ookpe_cfg_regs.sv -----
`timescale 1ns / 1ps

module ookpe_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ookpe_cfg_if.sink         i_cfg,
    output ookpe_pkg::t_cfg   o_cfg
);
    import ookpe_pkg::*;

    t_cfg     r_cfg;
    t_cfg_idx w_idx;

    assign i_cfg.ready = 1'b1;
    assign w_idx       = t_cfg_idx'(i_cfg.index);
    assign o_cfg       = r_cfg;

    // Register file, one write per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_high_factor  <= RST_ONE_HIGH;
            r_cfg.one_low_factor   <= RST_ONE_LOW;
            r_cfg.zero_high_factor <= RST_ZERO_HIGH;
            r_cfg.zero_low_factor  <= RST_ZERO_LOW;
            r_cfg.sync_high_factor <= RST_SYNC_HIGH;
            r_cfg.sync_low_factor  <= RST_SYNC_LOW;
            r_cfg.inverted_mode    <= 1'b0;
            r_cfg.pulse_unit       <= RST_UNIT;
        end else if (i_cfg.valid) begin
            case (w_idx)
                CFG_ONE_HIGH:  r_cfg.one_high_factor  <= i_cfg.data[FACT_W-1:0];
                CFG_ONE_LOW:   r_cfg.one_low_factor   <= i_cfg.data[FACT_W-1:0];
                CFG_ZERO_HIGH: r_cfg.zero_high_factor <= i_cfg.data[FACT_W-1:0];
                CFG_ZERO_LOW:  r_cfg.zero_low_factor  <= i_cfg.data[FACT_W-1:0];
                CFG_SYNC_HIGH: r_cfg.sync_high_factor <= i_cfg.data[FACT_W-1:0];
                CFG_SYNC_LOW:  r_cfg.sync_low_factor  <= i_cfg.data[FACT_W-1:0];
                CFG_INVERTED:  r_cfg.inverted_mode    <= i_cfg.data[0];
                CFG_UNIT:      r_cfg.pulse_unit       <= i_cfg.data[UNIT_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/core/ookpe_seq.sv -----
`timescale 1ns / 1ps

module ookpe_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ookpe_pkg::t_cfg  i_cfg,
    ookpe_in_if.sink         i_in,
    output logic             o_sym_valid,
    output ookpe_pkg::t_sym  o_sym,
    input  logic             i_sym_ready
);
    import ookpe_pkg::*;

    t_state              r_state, n_state;
    logic [FACT_W-1:0]   r_hf, n_hf;
    logic [FACT_W-1:0]   r_lf, n_lf;
    logic                r_sync, n_sync;
    logic [PROD_W-1:0]   r_hi, n_hi;
    logic [PROD_W-1:0]   r_lo, n_lo;

    logic                w_accept;
    logic [FACT_W-1:0]   w_sel_hf, w_sel_lf;
    logic [FACT_W-1:0]   w_mul_a;
    logic [PROD_W-1:0]   w_prod;
    logic                w_hi_gt, w_lo_gt;
    logic [PROD_W-1:0]   w_sub_a, w_diff;
    logic                w_step;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign o_sym_valid = (r_state == ST_EMIT_HI) || (r_state == ST_EMIT_LO);
    assign w_step      = o_sym_valid && i_sym_ready;

    // Factor pair for the incoming request
    always_comb begin
        if (i_in.command == CMD_SYNC) begin
            w_sel_hf = i_cfg.sync_high_factor;
            w_sel_lf = i_cfg.sync_low_factor;
        end else if (i_in.bit_value) begin
            w_sel_hf = i_cfg.one_high_factor;
            w_sel_lf = i_cfg.one_low_factor;
        end else begin
            w_sel_hf = i_cfg.zero_high_factor;
            w_sel_lf = i_cfg.zero_low_factor;
        end
    end

    // Shared multiplier: factor times pulse unit
    assign w_mul_a = (r_state == ST_MUL_HI) ? r_hf : r_lf;
    assign w_prod  = PROD_W'(w_mul_a) * PROD_W'(i_cfg.pulse_unit);

    // Shared compare and subtract unit for splitting long halves
    assign w_hi_gt = r_hi > MAX_HALF_TICKS;
    assign w_lo_gt = r_lo > MAX_HALF_TICKS;
    assign w_sub_a = (r_state == ST_EMIT_HI && w_hi_gt) ? r_hi : r_lo;
    assign w_diff  = w_sub_a - MAX_HALF_TICKS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hf   <= n_hf;
        r_lf   <= n_lf;
        r_sync <= n_sync;
        r_hi   <= n_hi;
        r_lo   <= n_lo;
    end

    // Next state and symbol forming
    always_comb begin
        n_state = r_state;
        n_hf    = r_hf;
        n_lf    = r_lf;
        n_sync  = r_sync;
        n_hi    = r_hi;
        n_lo    = r_lo;

        o_sym.first_duration  = '0;
        o_sym.first_level     = LVL_HIGH;
        o_sym.second_duration = '0;
        o_sym.second_level    = LVL_LOW;
        o_sym.from_sync       = r_sync;
        o_sym.last_symbol     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_hf   = w_sel_hf;
                    n_lf   = w_sel_lf;
                    n_sync = i_in.command;
                    // sync with both factors zero gives nothing
                    if (!(i_in.command == CMD_SYNC && w_sel_hf == '0 && w_sel_lf == '0)) begin
                        n_state = ST_MUL_HI;
                    end
                end
            end
            ST_MUL_HI: begin
                if (i_cfg.inverted_mode) n_lo = w_prod;
                else                     n_hi = w_prod;
                n_state = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                if (i_cfg.inverted_mode) n_hi = w_prod;
                else                     n_lo = w_prod;
                n_state = ST_EMIT_HI;
            end
            ST_EMIT_HI: begin
                if (w_hi_gt) begin
                    // high continuation symbol
                    o_sym.first_duration  = MAX_HALF_TICKS[DUR_W-1:0];
                    o_sym.second_level    = LVL_HIGH;
                    if (w_step) n_hi = w_diff;
                end else if (!w_lo_gt) begin
                    o_sym.first_duration  = r_hi[DUR_W-1:0];
                    o_sym.second_duration = r_lo[DUR_W-1:0];
                    o_sym.last_symbol     = 1'b1;
                    if (w_step) n_state = ST_IDLE;
                end else begin
                    // low half spills into further symbols
                    o_sym.first_duration  = r_hi[DUR_W-1:0];
                    o_sym.second_duration = MAX_HALF_TICKS[DUR_W-1:0];
                    if (w_step) begin
                        n_lo    = w_diff;
                        n_state = ST_EMIT_LO;
                    end
                end
            end
            ST_EMIT_LO: begin
                o_sym.first_level = LVL_LOW;
                if (w_lo_gt) begin
                    o_sym.first_duration = MAX_HALF_TICKS[DUR_W-1:0];
                    if (w_step) n_lo = w_diff;
                end else begin
                    o_sym.first_duration = r_lo[DUR_W-1:0];
                    o_sym.last_symbol    = 1'b1;
                    if (w_step) n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/ook_protocol_pulse_encoder.sv -----
`timescale 1ns / 1ps

// On-off keying pulse encoder. Each request item is a data bit or a frame
// sync; the block multiplies the chosen high and low factors by the pulse
// unit (swapped in inverted mode) and delivers the pair as a run of
// two-half symbols, halves longer than 32767 ticks split into continuation
// symbols, last_symbol set on the final one. A run normally holds one
// symbol and at most 63. A request is accepted, then makes two passes
// through the single shared 8x12 multiplier, then sends its symbols
// through the shared compare/subtract unit, held while the symbol channel
// stalls. A sync with both factors zero is accepted and gives no symbol.
// The request channel is not ready during that work; the final symbol
// sits in an output register, so the next request is taken while it
// waits. Register writes are taken in any cycle.
module ook_protocol_pulse_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ookpe_cfg_if.sink   i_cfg,
    ookpe_in_if.sink    i_in,
    ookpe_out_if.source o_out
);
    import ookpe_pkg::*;

    t_cfg w_cfg;
    logic w_sym_valid;
    t_sym w_sym;
    logic w_out_free;
    logic r_out_valid;
    t_sym r_out;

    ookpe_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    ookpe_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in        (i_in),
        .o_sym_valid (w_sym_valid),
        .o_sym       (w_sym),
        .i_sym_ready (w_out_free)
    );

    // Output register
    assign w_out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_sym_valid && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sym_valid && w_out_free) begin
            r_out <= w_sym;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.first_duration  = r_out.first_duration;
    assign o_out.first_level     = r_out.first_level;
    assign o_out.second_duration = r_out.second_duration;
    assign o_out.second_level    = r_out.second_level;
    assign o_out.from_sync       = r_out.from_sync;
    assign o_out.last_symbol     = r_out.last_symbol;

endmodule

// ----- dv/ookpe_symbol_checker.sv -----
`timescale 1ns / 1ps

// Watches the register, request and symbol channels, predicts the symbol
// runs from a shadow of the registers and compares every accepted symbol.
module ookpe_symbol_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ookpe_cfg_if  i_cfg,
    ookpe_in_if   i_in,
    ookpe_out_if  i_out,
    output int    o_fail_count,
    output int    o_pending
);
    import ookpe_pkg::*;

    localparam int unsigned HALF_LIMIT = 32'(MAX_HALF_TICKS);
    localparam int          MAX_RUN    = 64;

    t_cfg shadow_regs;
    t_sym expected_symbols[$];
    t_sym run_symbols[$];
    int   fail_count;
    int   pending_count;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // One symbol, level fields as given; last_symbol is set later on the run
    function automatic void add_symbol(input int unsigned d0, input logic l0,
                                       input int unsigned d1, input logic l1,
                                       input logic sync);
        t_sym s;
        if (run_symbols.size() >= MAX_RUN) return;
        s.first_duration  = DUR_W'(d0);
        s.first_level     = l0;
        s.second_duration = DUR_W'(d1);
        s.second_level    = l1;
        s.from_sync       = sync;
        s.last_symbol     = 1'b0;
        run_symbols = {run_symbols, s};
    endfunction

    // Works out the symbol run of one request and queues it
    function automatic void encode_request(input logic cmd, input logic bv);
        int unsigned high_f;
        int unsigned low_f;
        int unsigned high_t;
        int unsigned low_t;
        int unsigned swap_t;
        logic        is_sync;
        is_sync = (cmd == CMD_SYNC);
        if (is_sync) begin
            // sync with both factors zero yields nothing
            if (shadow_regs.sync_high_factor == '0 && shadow_regs.sync_low_factor == '0)
                return;
            high_f = shadow_regs.sync_high_factor;
            low_f  = shadow_regs.sync_low_factor;
        end else if (bv) begin
            high_f = shadow_regs.one_high_factor;
            low_f  = shadow_regs.one_low_factor;
        end else begin
            high_f = shadow_regs.zero_high_factor;
            low_f  = shadow_regs.zero_low_factor;
        end
        high_t = high_f * shadow_regs.pulse_unit;
        low_t  = low_f * shadow_regs.pulse_unit;
        // inverted mode swaps the tick counts only, levels stay high-then-low
        if (shadow_regs.inverted_mode) begin
            swap_t = high_t;
            high_t = low_t;
            low_t  = swap_t;
        end
        run_symbols.delete();
        // long high half: full-length continuation symbols first
        while (high_t > HALF_LIMIT && run_symbols.size() < MAX_RUN) begin
            add_symbol(HALF_LIMIT, LVL_HIGH, 0, LVL_HIGH, is_sync);
            high_t -= HALF_LIMIT;
        end
        if (high_t > HALF_LIMIT) high_t = HALF_LIMIT;
        if (low_t <= HALF_LIMIT) begin
            add_symbol(high_t, LVL_HIGH, low_t, LVL_LOW, is_sync);
        end else begin
            add_symbol(high_t, LVL_HIGH, HALF_LIMIT, LVL_LOW, is_sync);
            low_t -= HALF_LIMIT;
            while (low_t > HALF_LIMIT && run_symbols.size() < MAX_RUN) begin
                add_symbol(HALF_LIMIT, LVL_LOW, 0, LVL_LOW, is_sync);
                low_t -= HALF_LIMIT;
            end
            if (low_t > HALF_LIMIT) low_t = HALF_LIMIT;
            if (low_t > 0) add_symbol(low_t, LVL_LOW, 0, LVL_LOW, is_sync);
        end
        if (run_symbols.size() > 0) run_symbols[run_symbols.size()-1].last_symbol = 1'b1;
        expected_symbols = {expected_symbols, run_symbols};
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Sample all channels at the rising edge
    always @(posedge i_clk) begin
        t_sym want;
        if (!i_rst_n) begin
            shadow_regs.one_high_factor  = RST_ONE_HIGH;
            shadow_regs.one_low_factor   = RST_ONE_LOW;
            shadow_regs.zero_high_factor = RST_ZERO_HIGH;
            shadow_regs.zero_low_factor  = RST_ZERO_LOW;
            shadow_regs.sync_high_factor = RST_SYNC_HIGH;
            shadow_regs.sync_low_factor  = RST_SYNC_LOW;
            shadow_regs.inverted_mode    = 1'b0;
            shadow_regs.pulse_unit       = RST_UNIT;
            expected_symbols.delete();
        end else begin
            // symbol compare against the oldest expectation
            if (i_out.valid && i_out.ready) begin
                if (expected_symbols.size() == 0) begin
                    $error("symbol with no expectation: first_duration %0d second_duration %0d",
                           i_out.first_duration, i_out.second_duration);
                    fail_count++;
                end else begin
                    want = expected_symbols.pop_front();
                    check_field("first_duration", want.first_duration, i_out.first_duration);
                    check_field("first_level", want.first_level, i_out.first_level);
                    check_field("second_duration", want.second_duration,
                                i_out.second_duration);
                    check_field("second_level", want.second_level, i_out.second_level);
                    check_field("from_sync", want.from_sync, i_out.from_sync);
                    check_field("last_symbol", want.last_symbol, i_out.last_symbol);
                end
            end
            // register writes
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_ONE_HIGH:  shadow_regs.one_high_factor  = i_cfg.data[FACT_W-1:0];
                    CFG_ONE_LOW:   shadow_regs.one_low_factor   = i_cfg.data[FACT_W-1:0];
                    CFG_ZERO_HIGH: shadow_regs.zero_high_factor = i_cfg.data[FACT_W-1:0];
                    CFG_ZERO_LOW:  shadow_regs.zero_low_factor  = i_cfg.data[FACT_W-1:0];
                    CFG_SYNC_HIGH: shadow_regs.sync_high_factor = i_cfg.data[FACT_W-1:0];
                    CFG_SYNC_LOW:  shadow_regs.sync_low_factor  = i_cfg.data[FACT_W-1:0];
                    CFG_INVERTED:  shadow_regs.inverted_mode    = i_cfg.data[0];
                    CFG_UNIT:      shadow_regs.pulse_unit       = i_cfg.data[UNIT_W-1:0];
                    default: ;
                endcase
            end
            // requests
            if (i_in.valid && i_in.ready) encode_request(i_in.command, i_in.bit_value);
        end
        pending_count = expected_symbols.size();
    end

endmodule

// ----- dv/ook_protocol_pulse_encoder_test.sv -----
`timescale 1ns / 1ps

module ook_protocol_pulse_encoder_test;
    import ookpe_pkg::*;

    localparam int SETTLE_CYCLES    = 80;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int BATCH_ITEMS      = 72;
    localparam int RANDOM_BATCHES   = 6;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending_symbols;
    bit   src_idling;
    bit   sink_idling;
    bit   want_long_hold;

    ookpe_cfg_if reg_ch ();
    ookpe_in_if  req_ch ();
    ookpe_out_if sym_ch ();

    ook_protocol_pulse_encoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (reg_ch),
        .i_in    (req_ch),
        .o_out   (sym_ch)
    );

    ookpe_symbol_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (reg_ch),
        .i_in         (req_ch),
        .i_out        (sym_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_symbols)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Run limit
    initial begin
        #12_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Symbol receiver: random stall bursts, one long hold-off when asked
    initial begin : sink_pacing
        int  gap;
        bit  hold_done;
        hold_done    = 1'b0;
        sym_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (want_long_hold && !hold_done) begin
                hold_done = 1'b1;
                sym_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                sym_ch.ready <= 1'b1;
            end else if (sink_idling && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 8);
                sym_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
                sym_ch.ready <= 1'b1;
            end else begin
                sym_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one request; valid is left high for a following item
    task automatic send_request(input logic cmd, input logic bv);
        int gap;
        if (src_idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.command   <= cmd;
        req_ch.bit_value <= bv;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= value;
        do @(posedge i_clk); while (reg_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // Writes every register; unused upper data bits carry noise
    task automatic set_config(input int oh, input int ol, input int zh, input int zl,
                              input int sh, input int sl, input int inv, input int unit);
        write_reg(CFG_ONE_HIGH,  {4'($urandom_range(0, 15)), 8'(oh)});
        write_reg(CFG_ONE_LOW,   {4'($urandom_range(0, 15)), 8'(ol)});
        write_reg(CFG_ZERO_HIGH, {4'($urandom_range(0, 15)), 8'(zh)});
        write_reg(CFG_ZERO_LOW,  {4'($urandom_range(0, 15)), 8'(zl)});
        write_reg(CFG_SYNC_HIGH, {4'($urandom_range(0, 15)), 8'(sh)});
        write_reg(CFG_SYNC_LOW,  {4'($urandom_range(0, 15)), 8'(sl)});
        write_reg(CFG_INVERTED,  {11'($urandom), 1'(inv)});
        write_reg(CFG_UNIT,      12'(unit));
        reg_ch.valid <= 1'b0;
    endtask

    // Drop valid, wait for every symbol, then let a silent sync finish
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending_symbols != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic int pick_factor();
        return ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 255);
    endfunction

    // Stimulus
    initial begin
        int unit;
        src_idling       = 1'b1;
        sink_idling      = 1'b1;
        want_long_hold   = 1'b0;
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.command   = CMD_BIT;
        req_ch.bit_value = 1'b0;
        reg_ch.valid     = 1'b0;
        reg_ch.index     = CFG_ONE_HIGH;
        reg_ch.data      = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings
        send_request(CMD_BIT, 1'b0);
        send_request(CMD_BIT, 1'b1);
        send_request(CMD_SYNC, 1'b0);
        settle();
        // largest products: longest split runs
        set_config(255, 255, 255, 255, 255, 255, 0, 4095);
        send_request(CMD_BIT, 1'b1);
        send_request(CMD_SYNC, 1'b1);
        settle();
        set_config(255, 255, 255, 255, 255, 255, 1, 4095);
        send_request(CMD_BIT, 1'b0);
        settle();
        // zero factors: empty data symbol, silent sync
        set_config(0, 0, 0, 0, 0, 0, 0, 4095);
        send_request(CMD_BIT, 1'b0);
        send_request(CMD_BIT, 1'b1);
        send_request(CMD_SYNC, 1'b0);
        send_request(CMD_SYNC, 1'b1);
        settle();
        // halves of exactly the split limit
        set_config(217, 217, 217, 0, 0, 217, 0, 151);
        send_request(CMD_BIT, 1'b1);
        send_request(CMD_BIT, 1'b0);
        send_request(CMD_SYNC, 1'b0);
        settle();
        // halves one tick over the limit
        set_config(16, 16, 0, 16, 16, 0, 1, 2048);
        send_request(CMD_BIT, 1'b1);
        send_request(CMD_BIT, 1'b0);
        send_request(CMD_SYNC, 1'b1);
        settle();
        // smallest unit
        set_config(1, 1, 1, 1, 1, 1, 1, 1);
        send_request(CMD_BIT, 1'b0);
        send_request(CMD_BIT, 1'b1);
        send_request(CMD_SYNC, 1'b0);
        settle();

        // random batches, mostly short runs
        for (int batch = 0; batch < RANDOM_BATCHES; batch++) begin
            unit = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4095)
                                                : $urandom_range(1, 127);
            set_config(pick_factor(), pick_factor(), pick_factor(), pick_factor(),
                       pick_factor(), pick_factor(), $urandom_range(0, 1), unit);
            if (batch == 1) want_long_hold = 1'b1;
            if (batch == RANDOM_BATCHES - 1) begin
                src_idling  = 1'b0;
                sink_idling = 1'b0;
            end
            repeat (BATCH_ITEMS)
                send_request(($urandom_range(0, 3) == 0) ? CMD_SYNC : CMD_BIT,
                             1'($urandom_range(0, 1)));
            settle();
        end

        if (fail_count == 0 && pending_symbols == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/ookpe_pkg.sv
rtl/core/ookpe_ifs.sv
rtl/core/ookpe_cfg_regs.sv
rtl/core/ookpe_seq.sv
rtl/core/ook_protocol_pulse_encoder.sv
dv/ookpe_symbol_checker.sv
dv/ook_protocol_pulse_encoder_test.sv
